@@ hw/rtl/stq_pkg.sv @@
// Shared types and constants for the sorted timer expiry queue.
// Used by stq_scan, sorted_timer_expiry_queue and stq_checker.
`default_nettype none

package stq_pkg;

    localparam int MAX_RESULTS = 32;
    localparam int NCNT_W      = $clog2(MAX_RESULTS + 1);

    // slot word layout: {expiry, id, tag}
    localparam int EXP_W  = 32;
    localparam int ID_W   = 32;
    localparam int TAG_W  = 16;
    localparam int SLOT_W = EXP_W + ID_W + TAG_W;

    typedef enum logic [1:0] {
        OP_ADD  = 2'd0,
        OP_DEL  = 2'd1,
        OP_TICK = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        ST_ADDED    = 3'd0,
        ST_FULL     = 3'd1,
        ST_DELETED  = 3'd2,
        ST_NOTFOUND = 3'd3,
        ST_EXPIRED  = 3'd4,
        ST_NONEDUE  = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        MODE_FREE = 2'd0,
        MODE_ID   = 2'd1,
        MODE_DUE  = 2'd2
    } scan_mode_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_NEXT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic       start;
        scan_mode_t mode;
    } scan_req_t;

    typedef struct packed {
        logic done;
        logic found;
    } scan_rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/stq_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module stq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             clk,
    input  wire logic             we,
    input  wire logic [AW-1:0]    waddr,
    input  wire logic [WIDTH-1:0] wdata,
    input  wire logic [AW-1:0]    raddr,
    output logic      [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

@@ hw/rtl/stq_scan.sv @@
// Slot scanner: walks every slot once, one RAM read per cycle, and keeps
// the first free slot, the first id match or the earliest due timer.
// Depends on stq_pkg.
`default_nettype none

module stq_scan #(
    parameter int CAPACITY = 32,
    localparam int IDXW    = $clog2(CAPACITY)
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire stq_pkg::scan_req_t         req,
    input  wire logic [31:0]                key,
    input  wire logic [CAPACITY-1:0]        slot_valid,
    output logic      [IDXW-1:0]            rd_addr,
    input  wire logic [stq_pkg::SLOT_W-1:0] rd_data,
    output stq_pkg::scan_rsp_t              rsp,
    output logic      [IDXW-1:0]            best_idx,
    output logic      [31:0]                best_id,
    output logic      [15:0]                best_tag
);

    logic                 running_reg;
    logic [IDXW-1:0]      issue_idx_reg;
    logic                 cmp_vld_reg;
    logic                 cmp_last_reg;
    logic [IDXW-1:0]      cmp_idx_reg;
    logic                 done_reg;
    stq_pkg::scan_mode_t  mode_reg;
    logic                 found_reg;
    logic [IDXW-1:0]      best_idx_reg;
    logic [31:0]          best_exp_reg;
    logic [31:0]          best_id_reg;
    logic [15:0]          best_tag_reg;

    logic [31:0] rd_exp;
    logic [31:0] rd_id;
    logic [15:0] rd_tag;
    logic        slot_ok;
    logic        hit;
    logic        better;
    logic        take;
    logic        issue_last;

    assign rd_exp  = rd_data[stq_pkg::SLOT_W-1 -: stq_pkg::EXP_W];
    assign rd_id   = rd_data[stq_pkg::TAG_W +: stq_pkg::ID_W];
    assign rd_tag  = rd_data[stq_pkg::TAG_W-1:0];
    assign slot_ok = slot_valid[cmp_idx_reg];

    assign rd_addr    = issue_idx_reg;
    assign issue_last = (issue_idx_reg == IDXW'(CAPACITY - 1));

    always_comb
    begin
        hit    = 1'b0;
        better = 1'b0;
        unique case (mode_reg)
            stq_pkg::MODE_FREE:
            begin
                hit    = !slot_ok;
                better = !found_reg;
            end
            stq_pkg::MODE_ID:
            begin
                hit    = slot_ok && (rd_id == key);
                better = !found_reg;
            end
            stq_pkg::MODE_DUE:
            begin
                hit    = slot_ok && (rd_exp <= key);
                better = !found_reg || (rd_exp < best_exp_reg) ||
                         ((rd_exp == best_exp_reg) && (rd_id < best_id_reg));
            end
            default:
            begin
                hit    = 1'b0;
                better = 1'b0;
            end
        endcase
        take = cmp_vld_reg && hit && better;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_reg   <= 1'b0;
            issue_idx_reg <= '0;
            cmp_vld_reg   <= 1'b0;
            cmp_last_reg  <= 1'b0;
            cmp_idx_reg   <= '0;
            done_reg      <= 1'b0;
            mode_reg      <= stq_pkg::MODE_FREE;
            found_reg     <= 1'b0;
        end
        else
        begin
            cmp_vld_reg  <= running_reg;
            cmp_last_reg <= running_reg && issue_last;
            cmp_idx_reg  <= issue_idx_reg;
            // done once the last compare has been folded into the best slot
            done_reg     <= cmp_vld_reg && cmp_last_reg;
            if (req.start)
            begin
                running_reg   <= 1'b1;
                issue_idx_reg <= '0;
                mode_reg      <= req.mode;
                found_reg     <= 1'b0;
            end
            else
            begin
                if (running_reg)
                begin
                    issue_idx_reg <= issue_idx_reg + 1'b1;
                    if (issue_last)
                    begin
                        running_reg <= 1'b0;
                    end
                end
                if (take)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            best_idx_reg <= cmp_idx_reg;
            best_exp_reg <= rd_exp;
            best_id_reg  <= rd_id;
            best_tag_reg <= rd_tag;
        end
    end

    assign rsp.done  = done_reg;
    assign rsp.found = found_reg;
    assign best_idx  = best_idx_reg;
    assign best_id   = best_id_reg;
    assign best_tag  = best_tag_reg;

endmodule

`default_nettype wire

@@ hw/rtl/sorted_timer_expiry_queue.sv @@
// Sorted timer expiry queue, top level: sequencer, slot valid flags and id counter.
// Depends on stq_pkg, stq_ram and stq_scan.
//
// Holds up to CAPACITY timers (expiry, id, tag) in a RAM and serves one
// transaction at a time; in_ready is low while a transaction is at work.
// Every operation is one or more passes of a scanner that reads one slot per
// cycle. An add or a delete takes one pass, then loads its result. A tick
// that expires k timers takes k + 1 passes (k passes when k reaches 32, the
// most a single tick emits); due timers beyond 32 stay stored for a later
// tick. Results leave through an output register, so a new transaction is
// taken while the last result waits. Opcode 3 is accepted and ignored. No
// clearing pass is needed after reset.
`default_nettype none

module sorted_timer_expiry_queue #(
    parameter int CAPACITY = 32
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [1:0]  opcode,
    input  wire logic [31:0] time_value,
    input  wire logic [31:0] target_id,
    input  wire logic [15:0] user_tag,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [2:0]       status,
    output logic [31:0]      timer_id,
    output logic [15:0]      expired_tag,
    output logic             last
);

    localparam int IDXW = $clog2(CAPACITY);

    stq_pkg::state_t state_reg, state_next;

    logic [1:0]          op_reg, op_next;
    logic [31:0]         time_reg, time_next;
    logic [31:0]         target_reg, target_next;
    logic [15:0]         tag_reg, tag_next;
    logic [CAPACITY-1:0] slot_valid_reg, slot_valid_next;
    logic [31:0]         next_id_reg, next_id_next;
    logic [stq_pkg::NCNT_W-1:0] n_reg, n_next;
    logic                held_vld_reg, held_vld_next;
    logic [31:0]         held_id_reg, held_id_next;
    logic [15:0]         held_tag_reg, held_tag_next;

    stq_pkg::status_t    res_status_reg, res_status_next;
    logic [31:0]         res_id_reg, res_id_next;
    logic [15:0]         res_tag_reg, res_tag_next;
    logic                res_last_reg, res_last_next;

    logic                out_valid_reg, out_valid_next;
    stq_pkg::status_t    status_reg;
    logic [31:0]         timer_id_reg;
    logic [15:0]         expired_tag_reg;
    logic                last_reg;
    logic                out_load;

    stq_pkg::scan_req_t  scan_req;
    stq_pkg::scan_rsp_t  scan_rsp;
    logic [31:0]         scan_key;
    logic [IDXW-1:0]     best_idx;
    logic [31:0]         best_id;
    logic [15:0]         best_tag;

    logic                       ram_we;
    logic [stq_pkg::SLOT_W-1:0] ram_wdata;
    logic [IDXW-1:0]            ram_raddr;
    logic [stq_pkg::SLOT_W-1:0] ram_rdata;

    logic accept;
    logic out_free;

    assign in_ready = (state_reg == stq_pkg::S_IDLE);
    assign accept   = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;
    assign scan_key = (op_reg == stq_pkg::OP_DEL) ? target_reg : time_reg;
    assign ram_wdata = {time_reg, next_id_reg + 32'd1, tag_reg};

    stq_ram #(
        .WIDTH (stq_pkg::SLOT_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (best_idx),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    stq_scan #(
        .CAPACITY (CAPACITY)
    ) u_scan (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (scan_req),
        .key        (scan_key),
        .slot_valid (slot_valid_reg),
        .rd_addr    (ram_raddr),
        .rd_data    (ram_rdata),
        .rsp        (scan_rsp),
        .best_idx   (best_idx),
        .best_id    (best_id),
        .best_tag   (best_tag)
    );

    always_comb
    begin
        state_next      = state_reg;
        op_next         = op_reg;
        time_next       = time_reg;
        target_next     = target_reg;
        tag_next        = tag_reg;
        slot_valid_next = slot_valid_reg;
        next_id_next    = next_id_reg;
        n_next          = n_reg;
        held_vld_next   = held_vld_reg;
        held_id_next    = held_id_reg;
        held_tag_next   = held_tag_reg;
        res_status_next = res_status_reg;
        res_id_next     = res_id_reg;
        res_tag_next    = res_tag_reg;
        res_last_next   = res_last_reg;
        scan_req.start  = 1'b0;
        scan_req.mode   = stq_pkg::MODE_DUE;
        ram_we          = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            stq_pkg::S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = opcode;
                    time_next   = time_value;
                    target_next = target_id;
                    tag_next    = user_tag;
                    case (opcode)
                        stq_pkg::OP_ADD:
                        begin
                            scan_req.start = 1'b1;
                            scan_req.mode  = stq_pkg::MODE_FREE;
                            state_next     = stq_pkg::S_SCAN;
                        end
                        stq_pkg::OP_DEL:
                        begin
                            scan_req.start = 1'b1;
                            scan_req.mode  = stq_pkg::MODE_ID;
                            state_next     = stq_pkg::S_SCAN;
                        end
                        stq_pkg::OP_TICK:
                        begin
                            scan_req.start = 1'b1;
                            scan_req.mode  = stq_pkg::MODE_DUE;
                            n_next         = '0;
                            held_vld_next  = 1'b0;
                            state_next     = stq_pkg::S_SCAN;
                        end
                        default:
                        begin
                            state_next = stq_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            stq_pkg::S_SCAN:
            begin
                if (scan_rsp.done)
                begin
                    state_next    = stq_pkg::S_EMIT;
                    res_tag_next  = '0;
                    res_last_next = 1'b1;
                    case (op_reg)
                        stq_pkg::OP_ADD:
                        begin
                            if (scan_rsp.found)
                            begin
                                ram_we                    = 1'b1;
                                slot_valid_next[best_idx] = 1'b1;
                                next_id_next              = next_id_reg + 32'd1;
                                res_status_next           = stq_pkg::ST_ADDED;
                                res_id_next               = next_id_reg + 32'd1;
                            end
                            else
                            begin
                                res_status_next = stq_pkg::ST_FULL;
                                res_id_next     = '0;
                            end
                        end
                        stq_pkg::OP_DEL:
                        begin
                            res_id_next = target_reg;
                            if (scan_rsp.found)
                            begin
                                slot_valid_next[best_idx] = 1'b0;
                                res_status_next           = stq_pkg::ST_DELETED;
                            end
                            else
                            begin
                                res_status_next = stq_pkg::ST_NOTFOUND;
                            end
                        end
                        stq_pkg::OP_TICK:
                        begin
                            if (scan_rsp.found)
                            begin
                                slot_valid_next[best_idx] = 1'b0;
                                n_next        = n_reg + 1'b1;
                                held_vld_next = 1'b1;
                                held_id_next  = best_id;
                                held_tag_next = best_tag;
                                // previous due timer goes out, not the last one
                                res_status_next = stq_pkg::ST_EXPIRED;
                                res_id_next     = held_id_reg;
                                res_tag_next    = held_tag_reg;
                                res_last_next   = 1'b0;
                                if (!held_vld_reg)
                                begin
                                    state_next = stq_pkg::S_NEXT;
                                end
                            end
                            else if (held_vld_reg)
                            begin
                                res_status_next = stq_pkg::ST_EXPIRED;
                                res_id_next     = held_id_reg;
                                res_tag_next    = held_tag_reg;
                            end
                            else
                            begin
                                res_status_next = stq_pkg::ST_NONEDUE;
                                res_id_next     = '0;
                            end
                        end
                        default:
                        begin
                            state_next = stq_pkg::S_IDLE;
                        end
                    endcase
                end
            end

            stq_pkg::S_NEXT:
            begin
                if (n_reg == stq_pkg::NCNT_W'(stq_pkg::MAX_RESULTS))
                begin
                    res_status_next = stq_pkg::ST_EXPIRED;
                    res_id_next     = held_id_reg;
                    res_tag_next    = held_tag_reg;
                    res_last_next   = 1'b1;
                    state_next      = stq_pkg::S_EMIT;
                end
                else
                begin
                    scan_req.start = 1'b1;
                    scan_req.mode  = stq_pkg::MODE_DUE;
                    state_next     = stq_pkg::S_SCAN;
                end
            end

            stq_pkg::S_EMIT:
            begin
                if (out_free)
                begin
                    out_load   = 1'b1;
                    state_next = res_last_reg ? stq_pkg::S_IDLE : stq_pkg::S_NEXT;
                end
            end

            default:
            begin
                state_next = stq_pkg::S_IDLE;
            end
        endcase

        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= stq_pkg::S_IDLE;
            slot_valid_reg <= '0;
            next_id_reg    <= '0;
            n_reg          <= '0;
            held_vld_reg   <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            slot_valid_reg <= slot_valid_next;
            next_id_reg    <= next_id_next;
            n_reg          <= n_next;
            held_vld_reg   <= held_vld_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        time_reg       <= time_next;
        target_reg     <= target_next;
        tag_reg        <= tag_next;
        held_id_reg    <= held_id_next;
        held_tag_reg   <= held_tag_next;
        res_status_reg <= res_status_next;
        res_id_reg     <= res_id_next;
        res_tag_reg    <= res_tag_next;
        res_last_reg   <= res_last_next;
        if (out_load)
        begin
            status_reg      <= res_status_reg;
            timer_id_reg    <= res_id_reg;
            expired_tag_reg <= res_tag_reg;
            last_reg        <= res_last_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign timer_id    = timer_id_reg;
    assign expired_tag = expired_tag_reg;
    assign last        = last_reg;

endmodule

`default_nettype wire

@@ hw/rtl/stq_checker.sv @@
// Port-level checks for sorted_timer_expiry_queue, bound to the top level.
// Depends on stq_pkg.
`default_nettype none

module stq_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  status,
    input wire logic [31:0] timer_id,
    input wire logic [15:0] expired_tag,
    input wire logic        last
);

    // stalled result transaction holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(status) &&
        $stable(timer_id) && $stable(expired_tag) && $stable(last))
        else $error("result changed while stalled");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> status <= stq_pkg::ST_NONEDUE)
        else $error("undefined status code");

    // only expiries can be followed by further results
    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != stq_pkg::ST_EXPIRED |-> last)
        else $error("non-expiry result without last");

    a_tag_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != stq_pkg::ST_EXPIRED |-> expired_tag == 16'd0)
        else $error("tag on non-expiry result");

    a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status == stq_pkg::ST_FULL || status == stq_pkg::ST_NONEDUE)
        |-> timer_id == 32'd0)
        else $error("id on full or none-due result");

endmodule

bind sorted_timer_expiry_queue stq_checker u_stq_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .status      (status),
    .timer_id    (timer_id),
    .expired_tag (expired_tag),
    .last        (last)
);

`default_nettype wire
